FILE: hdl/yenc_pkg.sv
// ----------------------------------------------------------------------------
// yenc_pkg
// Shared types and character constants for the yEnc line encoder.
// ----------------------------------------------------------------------------
package yenc_pkg;

    localparam int LEN_W   = 12;   // line length register width
    localparam int COL_W   = 13;   // column counter width
    localparam int BURST_N = 4;    // most output bytes one input can cause
    localparam int CNT_W   = 3;    // holds 0..BURST_N

    localparam logic [LEN_W-1:0] LEN_RESET = 12'd128;

    localparam logic [7:0] ENC_OFFSET = 8'd42;
    localparam logic [7:0] ESC_OFFSET = 8'd64;
    localparam logic [7:0] ESC_CHAR   = 8'h3D;
    localparam logic [7:0] CR_CHAR    = 8'h0D;
    localparam logic [7:0] LF_CHAR    = 8'h0A;
    localparam logic [7:0] NUL_CHAR   = 8'h00;
    localparam logic [7:0] TAB_CHAR   = 8'h09;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       buffer_done;
    } t_out_item;

    // Output bytes of one input; entry 0 goes out first.
    typedef struct packed {
        logic [BURST_N-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
        logic                    eod;
    } t_burst;

endpackage

FILE: hdl/yenc_line_encoder.sv
// ----------------------------------------------------------------------------
// yenc_line_encoder
// yEnc encoder with escaping and CR LF line breaks.
// ----------------------------------------------------------------------------
// Each input beat yields one to four output beats: an optional CR LF line
// break, then the encoded byte or an '=' escape pair. The output register
// sends one beat per cycle while the sink is ready, so an input needs one
// output beat with no escape and no break, two with an escape, three with a
// break and four with both; with a ready sink a new input is taken every cycle
// in the plain case. The first output beat of an input is valid once the input
// register and then the burst register have taken it; a busy burst register
// holds it in the input register. The line length (reset 128) is capped at
// MAX_LINE_LENGTH and should only be written while the block is idle; the
// column position carries across end_of_data.
module yenc_line_encoder
    import yenc_pkg::*;
#(
    parameter int unsigned MAX_LINE_LENGTH = 4095
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_item         i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out_item        o_data
);

    localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
    localparam logic [LEN_W-1:0] LIMIT_CAP =
        LEN_W'((MAX_LINE_LENGTH > LEN_MAX) ? LEN_MAX : MAX_LINE_LENGTH);

    logic [LEN_W-1:0] r_line_length;
    logic [LEN_W-1:0] limit;
    logic             burst_valid;
    t_burst           burst;
    logic             burst_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LEN_RESET;
        end else if (i_cfg_we) begin
            r_line_length <= i_cfg_data;
        end
    end

    assign limit = (r_line_length > LIMIT_CAP) ? LIMIT_CAP : r_line_length;

    yenc_enc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_limit       (limit),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data        (i_data),
        .o_burst_valid (burst_valid),
        .o_burst       (burst),
        .i_burst_take  (burst_take)
    );

    yenc_burst_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_burst_valid (burst_valid),
        .i_burst       (burst),
        .o_load_ready  (burst_take),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data        (o_data)
    );

endmodule

FILE: hdl/yenc_enc_core.sv
// ----------------------------------------------------------------------------
// yenc_enc_core
// Input register, column counter and the encode/escape/line-break decision.
// ----------------------------------------------------------------------------
module yenc_enc_core
    import yenc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [LEN_W-1:0] i_limit,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_item         i_data,
    output logic             o_burst_valid,
    output t_burst           o_burst,
    input  logic             i_burst_take
);

    logic             r_in_valid;
    t_in_item         r_in;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;

    logic [COL_W-1:0] limit_ext;
    logic [COL_W-1:0] col0;
    logic [7:0]       enc;
    logic [7:0]       enc_esc;
    logic             brk;
    logic             esc;
    logic             take;

    assign take          = r_in_valid & i_burst_take;
    assign o_ready       = ~r_in_valid | i_burst_take;
    assign o_burst_valid = r_in_valid;

    assign limit_ext = {{(COL_W-LEN_W){1'b0}}, i_limit};
    assign enc       = r_in.data_byte + ENC_OFFSET;
    assign enc_esc   = enc + ESC_OFFSET;
    assign brk       = (r_col >= limit_ext);
    assign col0      = brk ? '0 : r_col;

    always_comb begin
        esc = (enc == NUL_CHAR) || (enc == LF_CHAR) || (enc == CR_CHAR) || (enc == ESC_CHAR);
        // first column: leading whitespace and dot
        if ((col0 == '0) && ((enc == TAB_CHAR) || (enc == SPACE_CHAR) || (enc == DOT_CHAR))) begin
            esc = 1'b1;
        end
        // last column: trailing whitespace
        if (((col0 + COL_W'(1)) == limit_ext) && ((enc == TAB_CHAR) || (enc == SPACE_CHAR))) begin
            esc = 1'b1;
        end
        n_col = col0 + (esc ? COL_W'(2) : COL_W'(1));
    end

    always_comb begin
        o_burst.eod = r_in.end_of_data;
        case ({brk, esc})
            2'b00: begin
                o_burst.bytes = {8'h00, 8'h00, 8'h00, enc};
                o_burst.count = CNT_W'(1);
            end
            2'b01: begin
                o_burst.bytes = {8'h00, 8'h00, enc_esc, ESC_CHAR};
                o_burst.count = CNT_W'(2);
            end
            2'b10: begin
                o_burst.bytes = {8'h00, enc, LF_CHAR, CR_CHAR};
                o_burst.count = CNT_W'(3);
            end
            default: begin
                o_burst.bytes = {enc_esc, ESC_CHAR, LF_CHAR, CR_CHAR};
                o_burst.count = CNT_W'(4);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_col      <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
            if (take) begin
                r_col <= n_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_data;
        end
    end

endmodule

FILE: hdl/yenc_burst_out.sv
// ----------------------------------------------------------------------------
// yenc_burst_out
// Output register that holds one input's burst and shifts it out a beat
// at a time.
// ----------------------------------------------------------------------------
module yenc_burst_out
    import yenc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_burst_valid,
    input  t_burst    i_burst,
    output logic      o_load_ready,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic [BURST_N-1:0][7:0] r_bytes;
    logic [CNT_W-1:0]        r_left;
    logic                    r_eod;
    logic                    last;

    assign last         = (r_left == CNT_W'(1));
    assign o_valid      = (r_left != '0);
    // reload in the same cycle the final beat leaves
    assign o_load_ready = (r_left == '0) || (last && i_ready);

    assign o_data.out_byte    = r_bytes[0];
    assign o_data.last_of_run = last;
    assign o_data.buffer_done = last & r_eod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_burst_valid && o_load_ready) begin
            r_left <= i_burst.count;
        end else if (o_valid && i_ready) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_burst_valid && o_load_ready) begin
            r_bytes <= i_burst.bytes;
            r_eod   <= i_burst.eod;
        end else if (o_valid && i_ready) begin
            r_bytes <= {8'h00, r_bytes[BURST_N-1:1]};
        end
    end

endmodule

FILE: hdl/yenc_checker.sv
// ----------------------------------------------------------------------------
// yenc_checker
// Port-level checks for the yEnc line encoder, bound to the top level.
// ----------------------------------------------------------------------------
module yenc_checker
    import yenc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled beat changed");

    // CR only comes from a line break, which is never the end of a run
    a_cr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.out_byte == CR_CHAR) |-> !i_out_data.last_of_run)
        else $error("CR ends a run");

    // '=' as data is always escaped, so a raw '=' is an escape lead-in
    a_esc_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.out_byte == ESC_CHAR) |-> !i_out_data.last_of_run)
        else $error("escape split from its byte");

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.buffer_done |-> i_out_data.last_of_run)
        else $error("buffer_done off the last beat");

endmodule

bind yenc_line_encoder yenc_checker u_yenc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_out_data  (o_data)
);

FILE: dv/tb_yenc_line_encoder.sv
// ----------------------------------------------------------------------------
// tb_yenc_line_encoder
// Self-checking bench for the yEnc line encoder.
// ----------------------------------------------------------------------------
// A directed table covers the always-escaped bytes, leading whitespace and dot
// at line start and mid line, trailing whitespace at the last column, line
// breaks and line lengths 0, 1, 4, 128 and 4095. Random phases then run biased
// byte streams at several line lengths. Input and output sides idle at random,
// and the sink holds off once for a long stretch. Every output beat is checked
// against a scoreboard queue that a local encoder model fills on each input.
module tb_yenc_line_encoder;
    import yenc_pkg::*;

    localparam int MAX_LINE_LEN   = 4095;
    localparam int IDLE_PCT       = 23;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_AT        = 100;   // sink output count that starts the long hold
    localparam int HOLD_CYCLES    = 64;
    localparam int CALM_LO        = 150;   // sink never stalls between these output counts
    localparam int CALM_HI        = 230;
    localparam int RAND_PHASES    = 6;
    localparam int PHASE_BEATS    = 25;
    localparam int MAX_REPORTS    = 10;

    // Raw bytes whose encoded value hits an escape candidate.
    localparam logic [7:0] NUL_RAW   = 8'hD6;
    localparam logic [7:0] LF_RAW    = 8'hE0;
    localparam logic [7:0] CR_RAW    = 8'hE3;
    localparam logic [7:0] ESC_RAW   = 8'h13;
    localparam logic [7:0] TAB_RAW   = 8'hDF;
    localparam logic [7:0] SPACE_RAW = 8'hF6;
    localparam logic [7:0] DOT_RAW   = 8'h04;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_cfg_we   = 1'b0;
    logic [LEN_W-1:0] i_cfg_data = '0;
    logic             i_valid    = 1'b0;
    logic             o_ready;
    t_in_item         i_data     = '0;
    logic             o_valid;
    logic             i_ready    = 1'b0;
    t_out_item        o_data;

    yenc_line_encoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Encoder model state and scoreboard.
    int        line_len    = 128;
    int        col_pos     = 0;
    t_out_item expected_q [$];
    int        err_count   = 0;
    int        out_count   = 0;
    int        in_count    = 0;
    int        break_count = 0;
    int        len_writes  = 0;
    int        quiet_cycles = 0;
    bit        send_calm   = 1'b0;
    int        hold_left   = 0;
    bit        hold_done   = 1'b0;

    typedef struct packed {
        logic             is_cfg;
        logic [LEN_W-1:0] len;
        logic [7:0]       data;
        logic             eod;
        logic [2:0]       n_typed;   // 0: expectation comes from the model
        logic [0:3][7:0]  typed;
    } t_dir_row;

    localparam int DIR_N = 27;

    // Starts from reset (line length 128, column 0).
    t_dir_row dir_tab [DIR_N] = '{
        '{1'b0, 12'd0,    DOT_RAW,   1'b0, 3'd2, {ESC_CHAR, 8'h6E, 8'h00, 8'h00}},
        '{1'b0, 12'd0,    NUL_RAW,   1'b0, 3'd2, {ESC_CHAR, 8'h40, 8'h00, 8'h00}},
        '{1'b0, 12'd0,    LF_RAW,    1'b0, 3'd2, {ESC_CHAR, 8'h4A, 8'h00, 8'h00}},
        '{1'b0, 12'd0,    CR_RAW,    1'b0, 3'd2, {ESC_CHAR, 8'h4D, 8'h00, 8'h00}},
        '{1'b0, 12'd0,    ESC_RAW,   1'b1, 3'd2, {ESC_CHAR, 8'h7D, 8'h00, 8'h00}},
        '{1'b0, 12'd0,    8'hFF,     1'b0, 3'd1, {8'h29, 8'h00, 8'h00, 8'h00}},
        '{1'b0, 12'd0,    8'h00,     1'b0, 3'd1, {8'h2A, 8'h00, 8'h00, 8'h00}},
        '{1'b0, 12'd0,    TAB_RAW,   1'b0, 3'd1, {TAB_CHAR, 8'h00, 8'h00, 8'h00}},
        '{1'b0, 12'd0,    SPACE_RAW, 1'b0, 3'd1, {SPACE_CHAR, 8'h00, 8'h00, 8'h00}},
        '{1'b0, 12'd0,    DOT_RAW,   1'b1, 3'd1, {DOT_CHAR, 8'h00, 8'h00, 8'h00}},
        // column is past 4, so the next byte opens a new line
        '{1'b1, 12'd4,    8'h00,     1'b0, 3'd0, 32'h0},
        '{1'b0, 12'd0,    SPACE_RAW, 1'b0, 3'd4, {CR_CHAR, LF_CHAR, ESC_CHAR, 8'h60}},
        '{1'b0, 12'd0,    8'h41,     1'b0, 3'd1, {8'h6B, 8'h00, 8'h00, 8'h00}},
        '{1'b0, 12'd0,    TAB_RAW,   1'b0, 3'd2, {ESC_CHAR, 8'h49, 8'h00, 8'h00}},
        '{1'b0, 12'd0,    8'h41,     1'b1, 3'd3, {CR_CHAR, LF_CHAR, 8'h6B, 8'h00}},
        '{1'b0, 12'd0,    DOT_RAW,   1'b0, 3'd0, 32'h0},
        '{1'b0, 12'd0,    SPACE_RAW, 1'b0, 3'd0, 32'h0},
        '{1'b0, 12'd0,    SPACE_RAW, 1'b0, 3'd0, 32'h0},
        // zero length: a break before every byte
        '{1'b1, 12'd0,    8'h00,     1'b0, 3'd0, 32'h0},
        '{1'b0, 12'd0,    DOT_RAW,   1'b0, 3'd0, 32'h0},
        '{1'b0, 12'd0,    8'h41,     1'b1, 3'd0, 32'h0},
        // length one: first column is also the last
        '{1'b1, 12'd1,    8'h00,     1'b0, 3'd0, 32'h0},
        '{1'b0, 12'd0,    TAB_RAW,   1'b0, 3'd0, 32'h0},
        '{1'b0, 12'd0,    8'h7A,     1'b0, 3'd0, 32'h0},
        '{1'b1, 12'd4095, 8'h00,     1'b0, 3'd0, 32'h0},
        '{1'b0, 12'd0,    8'hFF,     1'b0, 3'd0, 32'h0},
        '{1'b0, 12'd0,    8'h00,     1'b1, 3'd0, 32'h0}
    };

    function automatic void flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
    endfunction

    function automatic void push_expect(input logic [7:0] b, input bit last, input bit eod);
        t_out_item exp_beat;
        exp_beat.out_byte    = b;
        exp_beat.last_of_run = last;
        exp_beat.buffer_done = last && eod;
        expected_q.push_back(exp_beat);
    endfunction

    // Advances the encoder model by one input byte; queues its output if keep.
    function automatic void encode_beat(input t_in_item it, input bit keep);
        logic [7:0] enc;
        logic [7:0] seq [$];
        int         limit;
        bit         esc;
        limit = (line_len > MAX_LINE_LEN) ? MAX_LINE_LEN : line_len;
        enc   = it.data_byte + ENC_OFFSET;
        if (col_pos >= limit) begin
            seq.push_back(CR_CHAR);
            seq.push_back(LF_CHAR);
            col_pos = 0;
            break_count++;
        end
        esc = (enc == NUL_CHAR) || (enc == LF_CHAR) || (enc == CR_CHAR) || (enc == ESC_CHAR);
        if (col_pos == 0 && (enc == TAB_CHAR || enc == SPACE_CHAR || enc == DOT_CHAR))
            esc = 1'b1;
        if (col_pos + 1 == limit && (enc == TAB_CHAR || enc == SPACE_CHAR))
            esc = 1'b1;
        if (esc) begin
            seq.push_back(ESC_CHAR);
            seq.push_back(enc + ESC_OFFSET);
            col_pos += 2;
        end else begin
            seq.push_back(enc);
            col_pos += 1;
        end
        if (keep)
            foreach (seq[k])
                push_expect(seq[k], k == seq.size() - 1, it.end_of_data);
    endfunction

    task automatic send_beat(input t_in_item it, input bit keep);
        while (!send_calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        in_count++;
        encode_beat(it, keep);
    endtask

    // Line length is only changed with the encoder drained.
    task automatic set_line_length(input logic [LEN_W-1:0] len);
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        line_len = len;
        len_writes++;
    endtask

    // Output sink: random stalls, one long hold, one calm window.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (out_count == HOLD_AT && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= (out_count >= CALM_LO && out_count < CALM_HI) ||
                       ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            out_count <= out_count + 1;
            if (expected_q.size() == 0) begin
                flag_error($sformatf("unexpected beat byte=%02h last=%0b done=%0b",
                                     o_data.out_byte, o_data.last_of_run, o_data.buffer_done));
            end else begin
                want = expected_q.pop_front();
                if (o_data.out_byte !== want.out_byte ||
                    o_data.last_of_run !== want.last_of_run ||
                    o_data.buffer_done !== want.buffer_done)
                    flag_error($sformatf(
                        "beat %0d: exp byte=%02h last=%0b done=%0b, got byte=%02h last=%0b done=%0b",
                        out_count, want.out_byte, want.last_of_run, want.buffer_done,
                        o_data.out_byte, o_data.last_of_run, o_data.buffer_done));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles, %0d beats outstanding",
                     WATCHDOG_LIMIT, expected_q.size());
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_in_item   it;
        logic [7:0] special [7];
        int         rand_idx;
        special = '{NUL_RAW, LF_RAW, CR_RAW, ESC_RAW, TAB_RAW, SPACE_RAW, DOT_RAW};
        rand_idx = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].is_cfg) begin
                set_line_length(dir_tab[r].len);
            end else begin
                it.data_byte   = dir_tab[r].data;
                it.end_of_data = dir_tab[r].eod;
                for (int k = 0; k < dir_tab[r].n_typed; k++)
                    push_expect(dir_tab[r].typed[k], k == dir_tab[r].n_typed - 1, it.end_of_data);
                send_beat(it, dir_tab[r].n_typed == 0);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            // mostly short lines so breaks and last-column escapes are frequent
            if (p == 3)
                set_line_length(LEN_W'($urandom_range(13, MAX_LINE_LEN)));
            else
                set_line_length(LEN_W'($urandom_range(4, 12)));
            for (int i = 0; i < PHASE_BEATS; i++) begin
                if ($urandom_range(99) < 35)
                    it.data_byte = special[$urandom_range(6)];
                else
                    it.data_byte = 8'($urandom_range(255));
                it.end_of_data = ($urandom_range(7) == 0);
                send_calm = (rand_idx >= 60 && rand_idx < 100);
                send_beat(it, 1'b1);
                rand_idx++;
            end
        end
        send_calm = 1'b0;
        i_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0)
            flag_error($sformatf("%0d expected beats never arrived", expected_q.size()));

        $display("Encoded %0d input bytes into %0d output beats (%0d line breaks)",
                 in_count, out_count, break_count);
        $display("Line length written %0d times; %0d mismatches", len_writes, err_count);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/yenc_pkg.sv
hdl/yenc_enc_core.sv
hdl/yenc_burst_out.sv
hdl/yenc_line_encoder.sv
hdl/yenc_checker.sv
dv/tb_yenc_line_encoder.sv
